@@ rtl/fqrv_pkg.sv @@
// Shared types and constants for the ordered queue with remove-by-value.
// Used by fifo_queue_with_remove_by_value_core and the testbench; depends on nothing else.
package fqrv_pkg;

   // Operation codes carried in the request word.
   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_NOP    = 2'd3;

   // Fixed field widths of the request and response words.
   localparam int VALUE_W = 32;
   localparam int OCC_W   = 5;

   // One request word: operation and operand.
   typedef struct packed {
      logic [1:0]         op;
      logic [VALUE_W-1:0] value;
   } req_type;

   // One response word.
   typedef struct packed {
      logic [VALUE_W-1:0] out_value;
      logic               out_valid;
      logic               found;
      logic               overflow;
      logic               is_empty;
      logic [OCC_W-1:0]   occupancy;
   } rsp_type;

endpackage

@@ rtl/fifo_queue_with_remove_by_value_core.sv @@
// Ordered queue of up to DEPTH values with add, pop front and remove-first-match.
// Depends on fqrv_pkg for the request/response word types and operation codes.
//
// Usage:
//   A request word (req_data: op, value) is taken at a rising edge where start is
//   high and busy is low. busy stays high until the response has been shown.
//   Every request gives exactly one response word on rsp_data, valid for the
//   single cycle in which rsp_strobe is high; the receiver cannot hold it off.
//   Entries live in a memory with one write port and one registered read port; one
//   sequencer reuses one equality comparator, one index compare and one cursor register.
//   An add, a no-op or a pop on an empty queue goes straight to the response state.
//   A pop of a nonempty queue reads the front entry, then shifts every later entry
//   forward; a remove scans from the front for the first match and, on a match,
//   shifts the entries behind it forward. Each scan step is a read state then a
//   compare state, and each shift step a read state then a write state, since the
//   memory gives one registered read per step. A new request may be taken in the
//   cycle after the strobe.
//   Reset clears the entry count and the sequencer; memory contents are not
//   cleared, since no entry is read before it has been written.
module fifo_queue_with_remove_by_value_core #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fqrv_pkg::req_type req_data,
   output logic              rsp_strobe,
   output fqrv_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Sequencer state codes.
   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_POP_WAIT = 3'd1;
   localparam logic [2:0] ST_SC_RD    = 3'd2;
   localparam logic [2:0] ST_SC_CMP   = 3'd3;
   localparam logic [2:0] ST_SH_RD    = 3'd4;
   localparam logic [2:0] ST_SH_WR    = 3'd5;
   localparam logic [2:0] ST_RESP     = 3'd6;

   logic [WIDTH-1:0]  entry_mem [DEPTH];
   logic [WIDTH-1:0]  rd_data_ff;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  cur_ff, cur_in;
   logic [WIDTH-1:0]  val_ff, val_in;
   logic [WIDTH-1:0]  pop_val_ff, pop_val_in;
   logic              valid_ff, valid_in;
   logic              found_ff, found_in;
   logic              over_ff, over_in;

   logic              accept;
   logic [CNT_W-1:0]  cmp_a;
   logic              cur_lt_count;
   logic              val_eq;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [WIDTH-1:0]  wr_data;
   logic [WIDTH-1:0]  req_val;

   assign accept  = start && !busy;
   assign busy    = (state_ff != ST_IDLE);
   assign req_val = WIDTH'(req_data.value);

   // Shared units: one index compare and one value comparator.
   assign cmp_a        = (state_ff == ST_SH_RD) ? (cur_ff + CNT_W'(1)) : cur_ff;
   assign cur_lt_count = (cmp_a < count_ff);
   assign val_eq       = (rd_data_ff == val_ff);

   // Sequencer next-state and datapath control.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      cur_in     = cur_ff;
      val_in     = val_ff;
      pop_val_in = pop_val_ff;
      valid_in   = valid_ff;
      found_in   = found_ff;
      over_in    = over_ff;
      rd_addr    = '0;
      wr_en      = 1'b0;
      wr_addr    = cur_ff[IDX_W-1:0];
      wr_data    = rd_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               val_in     = req_val;
               pop_val_in = '0;
               valid_in   = 1'b0;
               found_in   = 1'b0;
               over_in    = 1'b0;
               cur_in     = '0;
               state_in   = ST_RESP;
               case (req_data.op)
                  fqrv_pkg::OP_ADD: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        over_in = 1'b1;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[IDX_W-1:0];
                        wr_data  = req_val;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  fqrv_pkg::OP_POP: begin
                     // Front entry is read at address zero.
                     if (count_ff != '0) begin
                        state_in = ST_POP_WAIT;
                     end
                  end
                  fqrv_pkg::OP_REMOVE: begin
                     state_in = ST_SC_RD;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_POP_WAIT: begin
            pop_val_in = rd_data_ff;
            valid_in   = 1'b1;
            state_in   = ST_SH_RD;
         end
         ST_SC_RD: begin
            // Read the next candidate, or finish with no match.
            rd_addr = cur_ff[IDX_W-1:0];
            if (cur_lt_count) begin
               state_in = ST_SC_CMP;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_SC_CMP: begin
            if (val_eq) begin
               found_in = 1'b1;
               state_in = ST_SH_RD;
            end else begin
               cur_in   = cur_ff + CNT_W'(1);
               state_in = ST_SC_RD;
            end
         end
         ST_SH_RD: begin
            // Fetch the entry behind the gap, or close out the shift.
            rd_addr = cmp_a[IDX_W-1:0];
            if (cur_lt_count) begin
               state_in = ST_SH_WR;
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = ST_RESP;
            end
         end
         ST_SH_WR: begin
            wr_en    = 1'b1;
            wr_addr  = cur_ff[IDX_W-1:0];
            wr_data  = rd_data_ff;
            cur_in   = cur_ff + CNT_W'(1);
            state_in = ST_SH_RD;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Entry memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Working and result registers.
   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      val_ff     <= val_in;
      pop_val_ff <= pop_val_in;
      valid_ff   <= valid_in;
      found_ff   <= found_in;
      over_ff    <= over_in;
   end

   // Response word, shown for the one cycle spent in the response state.
   assign rsp_strobe         = (state_ff == ST_RESP);
   assign rsp_data.out_value = fqrv_pkg::VALUE_W'(pop_val_ff);
   assign rsp_data.out_valid = valid_ff;
   assign rsp_data.found     = found_ff;
   assign rsp_data.overflow  = over_ff;
   assign rsp_data.is_empty  = (count_ff == '0);
   assign rsp_data.occupancy = fqrv_pkg::OCC_W'(count_ff);

`ifndef SYNTHESIS
   // The entry count never passes the queue depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds depth");

   // A dropped add only happens on a full queue.
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.overflow) |-> (count_ff == CNT_W'(DEPTH)))
      else $error("overflow reported on a queue that is not full");

   // A successful pop or remove leaves one entry fewer than before the request.
   a_shrink: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SH_RD && !cur_lt_count) |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("shift did not shrink the queue by one");

   // No new request is taken while a response is due.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !accept)
      else $error("request accepted during response cycle");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for fifo_queue_with_remove_by_value_core: directed and random words.
// Depends on fqrv_pkg and the core; a queue-based predictor checks every response word.
module testbench;

   localparam int QUEUE_DEPTH = 16;
   localparam int POOL_N      = 8;
   localparam int QUIET_LIMIT = 600;
   localparam int TAIL_CYCLES = 40;
   localparam int RANDOM_WORDS = 1750;

   // One pending request word; drain_first holds it back until all responses are in.
   typedef struct {
      fqrv_pkg::req_type word;
      bit                drain_first;
   } cmd_entry_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   fqrv_pkg::req_type req_data = '0;
   logic              rsp_strobe;
   fqrv_pkg::rsp_type rsp_data;

   cmd_entry_type     cmd_q[$];
   fqrv_pkg::rsp_type expected_rsp_q[$];
   logic [31:0]       held_values[$];
   logic [31:0]       value_pool[POOL_N];
   bit                word_taken = 1'b0;
   int                issued_count = 0;
   int                quiet_cycles = 0;
   int                mismatch_count = 0;

   fifo_queue_with_remove_by_value_core #(
      .DEPTH(QUEUE_DEPTH),
      .WIDTH(fqrv_pkg::VALUE_W)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Apply one accepted word to the shadow queue and return the response it should give.
   function automatic fqrv_pkg::rsp_type predict_result(fqrv_pkg::req_type w);
      fqrv_pkg::rsp_type r;
      int                hit;
      r = '0;
      hit = -1;
      case (w.op)
         fqrv_pkg::OP_ADD: begin
            if (held_values.size() >= QUEUE_DEPTH) r.overflow = 1'b1;
            else held_values.insert(held_values.size(), w.value);
         end
         fqrv_pkg::OP_POP: begin
            if (held_values.size() > 0) begin
               r.out_value = held_values.pop_front();
               r.out_valid = 1'b1;
            end
         end
         fqrv_pkg::OP_REMOVE: begin
            // Only the frontmost match goes; later duplicates stay.
            for (int i = 0; i < held_values.size(); i++) begin
               if (held_values[i] == w.value) begin
                  hit = i;
                  break;
               end
            end
            if (hit >= 0) begin
               held_values.delete(hit);
               r.found = 1'b1;
            end
         end
         default: ;
      endcase
      r.is_empty = (held_values.size() == 0);
      r.occupancy = fqrv_pkg::OCC_W'(held_values.size());
      return r;
   endfunction

   task automatic add_cmd(logic [1:0] op, logic [31:0] v, bit drain);
      cmd_entry_type c;
      c.word.op = op;
      c.word.value = v;
      c.drain_first = drain;
      cmd_q.insert(cmd_q.size(), c);
   endtask

   // Mostly values from a small pool so that removes find matches and duplicates occur.
   function automatic logic [31:0] pick_value(int pool_pct);
      if ($urandom_range(99) < pool_pct) return value_pool[$urandom_range(POOL_N - 1)];
      return $urandom;
   endfunction

   task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      mismatch_count++;
   endtask

   // Driver: a word stays on the port until taken, then the next one follows or the port idles.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !word_taken) begin
         start <= 1'b1;
      end else if (cmd_q.size() == 0) begin
         start <= 1'b0;
      end else if (cmd_q[0].drain_first && (expected_rsp_q.size() != 0 || busy)) begin
         start <= 1'b0;
      end else if (!(issued_count >= 700 && issued_count < 1000) &&
                   $urandom_range(99) < 32) begin
         start <= 1'b0;
      end else begin
         start <= 1'b1;
         req_data <= cmd_q[0].word;
         void'(cmd_q.pop_front());
         issued_count++;
      end
   end

   // Monitor: check the response word first, then predict for a word taken at this edge.
   always @(posedge clock) begin
      fqrv_pkg::rsp_type want;
      word_taken <= start && !busy && !reset;
      if (!reset && rsp_strobe) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: response word with none expected, actual 0x%0h", $time, rsp_data);
            mismatch_count++;
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_data.out_value !== want.out_value)
               report_field("out_value", want.out_value, rsp_data.out_value);
            if (rsp_data.out_valid !== want.out_valid)
               report_field("out_valid", 32'(want.out_valid), 32'(rsp_data.out_valid));
            if (rsp_data.found !== want.found)
               report_field("found", 32'(want.found), 32'(rsp_data.found));
            if (rsp_data.overflow !== want.overflow)
               report_field("overflow", 32'(want.overflow), 32'(rsp_data.overflow));
            if (rsp_data.is_empty !== want.is_empty)
               report_field("is_empty", 32'(want.is_empty), 32'(rsp_data.is_empty));
            if (rsp_data.occupancy !== want.occupancy)
               report_field("occupancy", 32'(want.occupancy), 32'(rsp_data.occupancy));
         end
      end
      if (!reset && start && !busy)
         expected_rsp_q.insert(expected_rsp_q.size(), predict_result(req_data));
   end

   // Watchdog: too long without a taken word or a response ends the run.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int total;
      int phase_kind;
      int phase_len;
      int roll;
      int add_lim;
      int pop_lim;
      int rem_lim;
      logic [1:0] op;

      value_pool[0] = '0;
      value_pool[1] = '1;
      for (int i = 2; i < POOL_N; i++) value_pool[i] = $urandom;

      // Directed words: empty-queue cases, no-op, extreme values, duplicates,
      // a miss, then a fill up to full, an add that overflows and a remove at the back.
      add_cmd(fqrv_pkg::OP_POP, 32'h0, 1'b0);
      add_cmd(fqrv_pkg::OP_REMOVE, 32'h0, 1'b0);
      add_cmd(fqrv_pkg::OP_NOP, 32'hFFFF_FFFF, 1'b0);
      add_cmd(fqrv_pkg::OP_ADD, 32'h0, 1'b0);
      add_cmd(fqrv_pkg::OP_ADD, 32'hFFFF_FFFF, 1'b0);
      add_cmd(fqrv_pkg::OP_ADD, 32'h5, 1'b0);
      add_cmd(fqrv_pkg::OP_ADD, 32'hFFFF_FFFF, 1'b0);
      add_cmd(fqrv_pkg::OP_ADD, 32'h9, 1'b0);
      add_cmd(fqrv_pkg::OP_REMOVE, 32'hFFFF_FFFF, 1'b0);
      add_cmd(fqrv_pkg::OP_REMOVE, 32'h1234, 1'b0);
      add_cmd(fqrv_pkg::OP_POP, 32'hFFFF_FFFF, 1'b0);
      add_cmd(fqrv_pkg::OP_NOP, 32'h0, 1'b0);
      for (int i = 0; i < 13; i++) add_cmd(fqrv_pkg::OP_ADD, 32'hA5A5_0000 + i, 1'b0);
      add_cmd(fqrv_pkg::OP_ADD, 32'h5A5A_5A5A, 1'b0);
      add_cmd(fqrv_pkg::OP_REMOVE, 32'hA5A5_000C, 1'b0);

      // Random phases, each leaning toward filling, draining or a mix of both.
      total = 0;
      while (total < RANDOM_WORDS) begin
         phase_kind = $urandom_range(2);
         phase_len = $urandom_range(80, 20);
         case (phase_kind)
            0: begin add_lim = 70; pop_lim = 80; rem_lim = 95; end
            1: begin add_lim = 15; pop_lim = 55; rem_lim = 95; end
            default: begin add_lim = 35; pop_lim = 60; rem_lim = 94; end
         endcase
         for (int n = 0; n < phase_len; n++) begin
            roll = $urandom_range(99);
            if (roll < add_lim) op = fqrv_pkg::OP_ADD;
            else if (roll < pop_lim) op = fqrv_pkg::OP_POP;
            else if (roll < rem_lim) op = fqrv_pkg::OP_REMOVE;
            else op = fqrv_pkg::OP_NOP;
            add_cmd(op, pick_value(op == fqrv_pkg::OP_REMOVE ? 85 : 75),
                    (n == 0) && ($urandom_range(7) == 0));
         end
         total += phase_len;
      end

      // The first random word waits for the directed words to finish.
      cmd_q[27].drain_first = 1'b1;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (cmd_q.size() != 0 || start) @(posedge clock);
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (expected_rsp_q.size() != 0) begin
         $display("%0t: %0d response words never arrived", $time, expected_rsp_q.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/fqrv_pkg.sv
rtl/fifo_queue_with_remove_by_value_core.sv
tb/testbench.sv
